// ===== hw/rtl/cpu6502_execute_unit_macros.svh =====
// ---------------------------------------------------------------------------
// cpu6502_execute_unit_macros.svh
// Assertion helpers shared by the execute unit RTL.
// ---------------------------------------------------------------------------
`ifndef CPU6502_EXECUTE_UNIT_MACROS_SVH
`define CPU6502_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C6502EU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C6502EU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/c6502eu_pkg.sv =====
// ---------------------------------------------------------------------------
// c6502eu_pkg
// Types, opcode codes and decode helpers of the 6502 execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package c6502eu_pkg;

  // Flag positions inside the six-bit flag register (N V D I Z C).
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_V = 4;
  localparam int FLAG_N = 5;

  localparam logic [7:0] SP_RESET   = 8'hfd;
  localparam logic [5:0] FLAGS_RESET = 6'b000100;

  // Opcodes with a behavior of their own.
  localparam logic [7:0] OP_NOP  = 8'hea;
  localparam logic [7:0] OP_JMP  = 8'h4c;
  localparam logic [7:0] OP_JMPI = 8'h6c;
  localparam logic [7:0] OP_JSR  = 8'h20;
  localparam logic [7:0] OP_RTS  = 8'h60;
  localparam logic [7:0] OP_RTI  = 8'h40;
  localparam logic [7:0] OP_PHP  = 8'h08;
  localparam logic [7:0] OP_PHA  = 8'h48;
  localparam logic [7:0] OP_PLP  = 8'h28;
  localparam logic [7:0] OP_PLA  = 8'h68;
  localparam logic [7:0] OP_DEX  = 8'hca;
  localparam logic [7:0] OP_DEY  = 8'h88;
  localparam logic [7:0] OP_INX  = 8'he8;
  localparam logic [7:0] OP_INY  = 8'hc8;
  localparam logic [7:0] OP_TAX  = 8'haa;
  localparam logic [7:0] OP_TXA  = 8'h8a;
  localparam logic [7:0] OP_TAY  = 8'ha8;
  localparam logic [7:0] OP_TYA  = 8'h98;
  localparam logic [7:0] OP_TSX  = 8'hba;
  localparam logic [7:0] OP_TXS  = 8'h9a;
  localparam logic [7:0] OP_CLC  = 8'h18;
  localparam logic [7:0] OP_SEC  = 8'h38;
  localparam logic [7:0] OP_CLI  = 8'h58;
  localparam logic [7:0] OP_SEI  = 8'h78;
  localparam logic [7:0] OP_CLD  = 8'hd8;
  localparam logic [7:0] OP_SED  = 8'hf8;
  localparam logic [7:0] OP_CLV  = 8'hb8;

  // Branch opcodes match xxy10000.
  localparam logic [4:0] BRANCH_LOW = 5'h10;

  // Low two opcode bits select the instruction group.
  localparam logic [1:0] GRP_CTL = 2'd0;
  localparam logic [1:0] GRP_ALU = 2'd1;
  localparam logic [1:0] GRP_RMW = 2'd2;

  // Group one operations (opcode bits 7:5).
  localparam logic [2:0] ALU_ORA = 3'd0;
  localparam logic [2:0] ALU_AND = 3'd1;
  localparam logic [2:0] ALU_EOR = 3'd2;
  localparam logic [2:0] ALU_ADC = 3'd3;
  localparam logic [2:0] ALU_STA = 3'd4;
  localparam logic [2:0] ALU_LDA = 3'd5;
  localparam logic [2:0] ALU_CMP = 3'd6;
  localparam logic [2:0] ALU_SBC = 3'd7;

  // Group two operations.
  localparam logic [2:0] RMW_ASL = 3'd0;
  localparam logic [2:0] RMW_ROL = 3'd1;
  localparam logic [2:0] RMW_LSR = 3'd2;
  localparam logic [2:0] RMW_ROR = 3'd3;
  localparam logic [2:0] RMW_STX = 3'd4;
  localparam logic [2:0] RMW_LDX = 3'd5;
  localparam logic [2:0] RMW_DEC = 3'd6;
  localparam logic [2:0] RMW_INC = 3'd7;
  localparam logic [2:0] MODE_ACC = 3'd2;

  // Group zero operations.
  localparam logic [2:0] CTL_BIT = 3'd1;
  localparam logic [2:0] CTL_STY = 3'd4;
  localparam logic [2:0] CTL_LDY = 3'd5;
  localparam logic [2:0] CTL_CPY = 3'd6;

  // Branch condition select (opcode bits 7:6).
  localparam logic [1:0] BR_N = 2'd0;
  localparam logic [1:0] BR_V = 2'd1;
  localparam logic [1:0] BR_C = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;

  // Bit n of row r set: opcode {r, n} is a documented, handled instruction.
  localparam logic [15:0] LEGAL_ROWS [16] = '{
    16'h6762, 16'h6363, 16'h7773, 16'h6363, 16'h7763, 16'h6363, 16'h7763, 16'h6363,
    16'h7572, 16'h2773, 16'h7777, 16'h7773, 16'h7773, 16'h6363, 16'h7773, 16'h6363
  };

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [5:0] p;
  } c6502eu_arch_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic       unknown_opcode;
    logic       branch_taken;
    logic       write_enable;
    logic [7:0] write_data;
  } c6502eu_res_t;

  function automatic logic is_legal(input logic [7:0] op);
    logic [15:0] row;
    row = LEGAL_ROWS[op[7:4]];
    return row[op[3:0]];
  endfunction

  // Returns {N, Z} for a result byte.
  function automatic logic [1:0] nz_of(input logic [7:0] v);
    return {v[7], (v == 8'h00)};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/c6502eu_exec.sv =====
// ---------------------------------------------------------------------------
// c6502eu_exec
// Combinational execute logic: next register state and result of one opcode.
// ---------------------------------------------------------------------------
`default_nettype none

module c6502eu_exec (
  input  wire logic [7:0]                 opcode,
  input  wire logic [7:0]                 operand,
  input  wire c6502eu_pkg::c6502eu_arch_t cur,
  output c6502eu_pkg::c6502eu_arch_t      nxt,
  output c6502eu_pkg::c6502eu_res_t       res
);
  import c6502eu_pkg::*;

  logic [1:0] grp;
  logic [2:0] aaa;
  logic       acc_mode;
  logic [7:0] add_b;
  logic [8:0] sum;
  logic       add_v;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_d;
  logic [7:0] src;

  assign grp      = opcode[1:0];
  assign aaa      = opcode[7:5];
  assign acc_mode = (opcode[4:2] == MODE_ACC);

  // One adder serves ADC and SBC: subtract is add of the inverted operand.
  assign add_b = (aaa == ALU_SBC) ? ~operand : operand;
  assign sum   = {1'b0, cur.a} + {1'b0, add_b} + {8'h00, cur.p[FLAG_C]};
  assign add_v = (cur.a[7] ^ sum[7]) & (add_b[7] ^ sum[7]);

  assign cmp_reg = (grp == GRP_ALU) ? cur.a :
                   (aaa == CTL_CPY) ? cur.y : cur.x;
  assign cmp_d   = {1'b0, cmp_reg} - {1'b0, operand};

  assign src = acc_mode ? cur.a : operand;

  always_comb begin
    logic       handled;
    logic       taken;
    logic [7:0] wdata;
    logic       wen;
    logic [7:0] rmw_res;
    logic       rmw;
    logic       bflag;

    nxt     = cur;
    handled = 1'b1;
    taken   = 1'b0;
    wdata   = 8'h00;
    wen     = 1'b0;
    rmw_res = 8'h00;
    rmw     = 1'b0;
    bflag   = 1'b0;

    if (!is_legal(opcode)) begin
      handled = 1'b1;
    end else begin
      unique case (opcode)
        OP_NOP, OP_JMP, OP_JMPI: ;
        OP_JSR: nxt.sp = cur.sp - 8'd2;
        OP_RTS: nxt.sp = cur.sp + 8'd2;
        OP_RTI: begin
          nxt.p  = {operand[7:6], operand[3:0]};
          nxt.sp = cur.sp + 8'd3;
        end
        OP_PHP: begin
          wdata  = {cur.p[FLAG_N], cur.p[FLAG_V], 2'b11, cur.p[FLAG_D],
                    cur.p[FLAG_I], cur.p[FLAG_Z], cur.p[FLAG_C]};
          wen    = 1'b1;
          nxt.sp = cur.sp - 8'd1;
        end
        OP_PHA: begin
          wdata  = cur.a;
          wen    = 1'b1;
          nxt.sp = cur.sp - 8'd1;
        end
        OP_PLP: begin
          nxt.p  = {operand[7:6], operand[3:0]};
          nxt.sp = cur.sp + 8'd1;
        end
        OP_PLA: begin
          nxt.a = operand;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(operand);
          nxt.sp = cur.sp + 8'd1;
        end
        OP_DEX: begin
          nxt.x = cur.x - 8'd1;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(nxt.x);
        end
        OP_DEY: begin
          nxt.y = cur.y - 8'd1;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(nxt.y);
        end
        OP_INX: begin
          nxt.x = cur.x + 8'd1;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(nxt.x);
        end
        OP_INY: begin
          nxt.y = cur.y + 8'd1;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(nxt.y);
        end
        OP_TAX: begin
          nxt.x = cur.a;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(cur.a);
        end
        OP_TXA: begin
          nxt.a = cur.x;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(cur.x);
        end
        OP_TAY: begin
          nxt.y = cur.a;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(cur.a);
        end
        OP_TYA: begin
          nxt.a = cur.y;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(cur.y);
        end
        OP_TSX: begin
          nxt.x = cur.sp;
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(cur.sp);
        end
        OP_TXS: nxt.sp = cur.x;
        OP_CLC: nxt.p[FLAG_C] = 1'b0;
        OP_SEC: nxt.p[FLAG_C] = 1'b1;
        OP_CLI: nxt.p[FLAG_I] = 1'b0;
        OP_SEI: nxt.p[FLAG_I] = 1'b1;
        OP_CLD: nxt.p[FLAG_D] = 1'b0;
        OP_SED: nxt.p[FLAG_D] = 1'b1;
        OP_CLV: nxt.p[FLAG_V] = 1'b0;
        default: handled = 1'b0;
      endcase

      if (!handled && (opcode[4:0] == BRANCH_LOW)) begin
        unique case (opcode[7:6])
          BR_N:    bflag = cur.p[FLAG_N];
          BR_V:    bflag = cur.p[FLAG_V];
          BR_C:    bflag = cur.p[FLAG_C];
          default: bflag = cur.p[FLAG_Z];
        endcase
        taken = (bflag == opcode[5]);
      end else if (!handled && (grp == GRP_ALU)) begin
        unique case (aaa)
          ALU_ORA: nxt.a = cur.a | operand;
          ALU_AND: nxt.a = cur.a & operand;
          ALU_EOR: nxt.a = cur.a ^ operand;
          ALU_STA: begin
            wdata = cur.a;
            wen   = 1'b1;
          end
          ALU_LDA: nxt.a = operand;
          ALU_CMP: nxt.p[FLAG_C] = ~cmp_d[8];
          default: begin
            // ADC and SBC share the adder.
            nxt.a         = sum[7:0];
            nxt.p[FLAG_C] = sum[8];
            nxt.p[FLAG_V] = add_v;
          end
        endcase
        if (aaa == ALU_CMP) begin
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(cmp_d[7:0]);
        end else if (aaa != ALU_STA) begin
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(nxt.a);
        end
      end else if (!handled && (grp == GRP_RMW)) begin
        rmw = 1'b1;
        unique case (aaa)
          RMW_ASL, RMW_ROL: begin
            nxt.p[FLAG_C] = src[7];
            rmw_res = {src[6:0], (aaa == RMW_ROL) & cur.p[FLAG_C]};
          end
          RMW_LSR, RMW_ROR: begin
            nxt.p[FLAG_C] = src[0];
            rmw_res = {(aaa == RMW_ROR) & cur.p[FLAG_C], src[7:1]};
          end
          RMW_STX: begin
            wdata = cur.x;
            wen   = 1'b1;
            rmw   = 1'b0;
          end
          RMW_LDX: begin
            nxt.x = operand;
            {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(operand);
            rmw   = 1'b0;
          end
          RMW_DEC: rmw_res = src - 8'd1;
          default: rmw_res = src + 8'd1;
        endcase
        if (rmw) begin
          {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(rmw_res);
          if (acc_mode) begin
            nxt.a = rmw_res;
          end else begin
            wdata = rmw_res;
            wen   = 1'b1;
          end
        end
      end else if (!handled) begin
        unique case (aaa)
          CTL_BIT: begin
            nxt.p[FLAG_Z] = ((cur.a & operand) == 8'h00);
            nxt.p[FLAG_V] = operand[6];
            nxt.p[FLAG_N] = operand[7];
          end
          CTL_STY: begin
            wdata = cur.y;
            wen   = 1'b1;
          end
          CTL_LDY: begin
            nxt.y = operand;
            {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(operand);
          end
          default: begin
            // CPY and CPX; the compare register was picked above.
            nxt.p[FLAG_C] = ~cmp_d[8];
            {nxt.p[FLAG_N], nxt.p[FLAG_Z]} = nz_of(cmp_d[7:0]);
          end
        endcase
      end
    end

    res.write_data     = wen ? wdata : 8'h00;
    res.write_enable   = wen;
    res.branch_taken   = taken;
    res.unknown_opcode = ~is_legal(opcode);
    res.status_byte    = {nxt.p[FLAG_N], nxt.p[FLAG_V], 2'b10, nxt.p[FLAG_D],
                          nxt.p[FLAG_I], nxt.p[FLAG_Z], nxt.p[FLAG_C]};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/c6502eu_regs.sv =====
// ---------------------------------------------------------------------------
// c6502eu_regs
// Architectural registers A, X, Y, SP and flags, loaded from arch_nxt whenever update is set.
// ---------------------------------------------------------------------------
`default_nettype none

module c6502eu_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       update,
  input  wire c6502eu_pkg::c6502eu_arch_t arch_nxt,
  output c6502eu_pkg::c6502eu_arch_t      arch
);
  import c6502eu_pkg::*;

  c6502eu_arch_t arch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r.a  <= 8'h00;
      arch_r.x  <= 8'h00;
      arch_r.y  <= 8'h00;
      arch_r.sp <= SP_RESET;
      arch_r.p  <= FLAGS_RESET;
    end else if (update) begin
      arch_r <= arch_nxt;
    end
  end

  assign arch = arch_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cpu6502_execute_unit.sv =====
// ---------------------------------------------------------------------------
// cpu6502_execute_unit
// Execute stage of a 6502-style core without decimal arithmetic. Each input
// transaction carries one opcode and its already fetched operand byte; each
// output transaction carries the write-back byte, write, branch and
// unknown-opcode flags and the status byte after the instruction. The unit
// holds A, X, Y, SP and the N V D I Z C flags. An instruction is held in the
// input register, executed by combinational logic against the register
// file, and lands in the output register. Throughput is one instruction per
// cycle while out_tready does not hold the output, set by the single execute
// stage. The register file is written on the same edge that loads the output
// register, so the very next instruction already sees the new state. The input
// side keeps accepting while a result waits, as long as the input register is
// free or moving. Unknown opcodes (undocumented ones and BRK) leave the state
// untouched and are reported with the unknown-opcode flag.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cpu6502_execute_unit_macros.svh"

module cpu6502_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input transactions.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] opcode, [15:8] operand_data
  // Result transactions.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [7:0] write_data, [8] write_enable,
                                       // [9] branch_taken, [10] unknown_opcode,
                                       // [18:11] status_byte, [23:19] zero
);
  import c6502eu_pkg::*;

  // Input register stage.
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_opcode_r;
  logic [7:0] s1_operand_r;

  // Output register stage.
  logic         out_valid_r;
  logic         out_valid_nxt;
  c6502eu_res_t out_res_r;

  logic          out_adv;
  logic          exec_fire;
  c6502eu_arch_t arch;
  c6502eu_arch_t arch_nxt;
  c6502eu_res_t  exec_res;

  // The output register can take a new result when it is empty or being
  // drained this cycle; the instruction in the input register executes then.
  assign out_adv   = !out_valid_r || out_tready;
  assign exec_fire = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_opcode_r  <= in_tdata[7:0];
      s1_operand_r <= in_tdata[15:8];
    end
    if (exec_fire) begin
      out_res_r <= exec_res;
    end
  end

  c6502eu_exec u_exec (
    .opcode  (s1_opcode_r),
    .operand (s1_operand_r),
    .cur     (arch),
    .nxt     (arch_nxt),
    .res     (exec_res)
  );

  // Unknown opcodes must leave the state as it was.
  c6502eu_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .update   (exec_fire && !exec_res.unknown_opcode),
    .arch_nxt (arch_nxt),
    .arch     (arch)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_res_r};

  `C6502EU_ASSERT_IMPLY(a_unknown_quiet, clk, rst_n, out_valid_r && out_res_r.unknown_opcode, !out_res_r.write_enable && !out_res_r.branch_taken, "unknown opcode produced a write or branch")
  `C6502EU_ASSERT_IMPLY(a_wdata_zero, clk, rst_n, out_valid_r && !out_res_r.write_enable, out_res_r.write_data == 8'h00, "write data nonzero without write enable")
  `C6502EU_ASSERT_IMPLY(a_status_fixed, clk, rst_n, out_valid_r, out_res_r.status_byte[5] && !out_res_r.status_byte[4], "status byte fixed bits wrong")
  `C6502EU_ASSERT_NEXT(a_state_hold, clk, rst_n, !exec_fire, $stable(arch), "register file changed without an executed instruction")
  `C6502EU_ASSERT_NEXT(a_result_follows, clk, rst_n, exec_fire, out_valid_r, "executed instruction did not reach the output register")

endmodule

`default_nettype wire
